FILE: rtl/csm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csm_pkg
// Shared types and constants of the contiguous subsequence matcher.
// ----------------------------------------------------------------------------
package csm_pkg;

   localparam int MAX_PATTERN_DEF = 16;
   localparam int DATA_WIDTH_DEF  = 32;
   localparam int VALUE_WIDTH     = 32;

   localparam logic OP_PATTERN = 1'b0;
   localparam logic OP_TEXT    = 1'b1;

   // Strobes that the controller sends to every cell of the row.
   typedef struct packed {
      logic pat_wr;
      logic txt_step;
      logic txt_clear;
   } cell_ctrl_type;

endpackage
`default_nettype wire

FILE: rtl/csm_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csm_req_if
// Input channel: pattern and text words with valid/ready handshake.
// ----------------------------------------------------------------------------
interface csm_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  op;
   logic signed [csm_pkg::VALUE_WIDTH-1:0] value;
   logic                                  last;

   modport source (output valid, output op, output value, output last, input ready);
   modport sink   (input valid, input op, input value, input last, output ready);
endinterface
`default_nettype wire

FILE: rtl/csm_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csm_rsp_if
// Result channel: one word per completed text, with valid/ready handshake.
// ----------------------------------------------------------------------------
interface csm_rsp_if;
   logic valid;
   logic ready;
   logic found;
   logic pattern_overflow;

   modport source (output valid, output found, output pattern_overflow, input ready);
   modport sink   (input valid, input found, input pattern_overflow, output ready);
endinterface
`default_nettype wire

FILE: rtl/csm_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csm_cell
// One position of the matcher row. Holds one pattern element and a flag that
// says the text words ending at the previous step equal the pattern prefix
// up to and including this cell. The flag moves one cell to the right per
// text word.
// ----------------------------------------------------------------------------
module csm_cell #(
   parameter int DATA_WIDTH = 32,
   parameter int LEN_WIDTH  = 5,
   parameter int CELL_INDEX = 0
) (
   input  wire                          clock,
   input  wire                          reset,
   input  csm_pkg::cell_ctrl_type       ctrl,
   input  wire [LEN_WIDTH-1:0]          wr_index,
   input  wire [LEN_WIDTH-1:0]          pat_len,
   input  wire [DATA_WIDTH-1:0]         data,
   input  wire                          prefix_prev,
   output logic                         prefix_out,
   output logic                         hit
);
   import csm_pkg::*;

   logic [DATA_WIDTH-1:0] pat_ff;
   logic                  prefix_ff;
   logic                  prefix_in;
   logic                  prefix_now;
   logic                  is_tail;

   // Prefix of length CELL_INDEX+1 ends at the word being accepted.
   assign prefix_now = prefix_prev & (data == pat_ff);
   assign is_tail    = (pat_len == LEN_WIDTH'(CELL_INDEX + 1));
   assign hit        = ctrl.txt_step & prefix_now & is_tail;
   assign prefix_out = prefix_ff;

   always_comb begin
      prefix_in = prefix_ff;
      if (ctrl.txt_clear) begin
         prefix_in = 1'b0;
      end else if (ctrl.txt_step) begin
         prefix_in = prefix_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff <= 1'b0;
      end else begin
         prefix_ff <= prefix_in;
      end
      if (ctrl.pat_wr && (wr_index == LEN_WIDTH'(CELL_INDEX))) begin
         pat_ff <= data;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/contiguous_subsequence_matcher.sv
`default_nettype none
// ----------------------------------------------------------------------------
// contiguous_subsequence_matcher
// Tells whether a stored pattern occurs as a contiguous run in a text stream.
// ----------------------------------------------------------------------------
// Pattern words (op 0) are written into a row of MAX_PATTERN cells, one cell
// per element, until the word marked last; text words (op 1) are then
// broadcast to every cell, and each cell compares the word with its pattern
// element and passes a prefix-match flag to its right neighbor. A new word,
// pattern or text, is taken in each cycle while the result register is free
// or being read. The result word is registered and appears in the cycle
// after the last text word; its path is one element compare per cell plus
// an OR across the row. An empty pattern always reports found, and a pattern
// longer than MAX_PATTERN reports pattern_overflow with found low.
// A pattern word after a completed pattern starts a new pattern.
// ----------------------------------------------------------------------------
module contiguous_subsequence_matcher #(
   parameter int MAX_PATTERN = csm_pkg::MAX_PATTERN_DEF,
   parameter int DATA_WIDTH  = csm_pkg::DATA_WIDTH_DEF
) (
   input  wire        clock,
   input  wire        reset,
   csm_req_if.sink    req_ch,
   csm_rsp_if.source  rsp_ch
);
   import csm_pkg::*;

   localparam int LEN_WIDTH = $clog2(MAX_PATTERN + 1);

   logic [LEN_WIDTH-1:0]   len_ff, len_in;
   logic                   closed_ff, closed_in;
   logic                   ovf_ff, ovf_in;
   logic                   seen_ff, seen_in;
   logic                   rsp_valid_ff;
   logic                   found_ff;
   logic                   rsp_ovf_ff;

   logic                   accept;
   logic                   is_pat;
   logic                   is_txt;
   logic                   restart;
   logic [LEN_WIDTH-1:0]   base_len;
   logic                   room;
   logic                   hit;
   logic [DATA_WIDTH-1:0]  data;
   cell_ctrl_type          ctrl;
   logic [MAX_PATTERN:0]   prefix_chain;
   logic [MAX_PATTERN-1:0] cell_hit;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign is_pat       = accept && (req_ch.op == OP_PATTERN);
   assign is_txt       = accept && (req_ch.op == OP_TEXT);
   assign restart      = is_pat && closed_ff;
   assign base_len     = restart ? '0 : len_ff;
   assign room         = (base_len < LEN_WIDTH'(MAX_PATTERN));
   assign data         = DATA_WIDTH'($unsigned(req_ch.value));

   assign ctrl.pat_wr    = is_pat && room;
   assign ctrl.txt_step  = is_txt;
   assign ctrl.txt_clear = (is_txt && req_ch.last) || restart;

   // The empty prefix matches at every position.
   assign prefix_chain[0] = 1'b1;

   for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
      csm_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .LEN_WIDTH  (LEN_WIDTH),
         .CELL_INDEX (k)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .wr_index    (base_len),
         .pat_len     (len_ff),
         .data        (data),
         .prefix_prev (prefix_chain[k]),
         .prefix_out  (prefix_chain[k+1]),
         .hit         (cell_hit[k])
      );
   end

   assign hit = (len_ff == '0) || (|cell_hit);

   always_comb begin
      len_in    = len_ff;
      closed_in = closed_ff;
      ovf_in    = ovf_ff;
      seen_in   = seen_ff;
      if (is_pat) begin
         len_in    = room ? base_len + LEN_WIDTH'(1) : base_len;
         ovf_in    = (!restart && ovf_ff) || !room;
         closed_in = req_ch.last;
         seen_in   = restart ? 1'b0 : seen_ff;
      end else if (is_txt) begin
         closed_in = 1'b1;
         seen_in   = req_ch.last ? 1'b0 : (seen_ff || hit);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         closed_ff    <= 1'b0;
         ovf_ff       <= 1'b0;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff    <= len_in;
         closed_ff <= closed_in;
         ovf_ff    <= ovf_in;
         seen_ff   <= seen_in;
         if (is_txt && req_ch.last) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (is_txt && req_ch.last) begin
         found_ff   <= !ovf_ff && (seen_ff || hit);
         rsp_ovf_ff <= ovf_ff;
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.found            = found_ff;
   assign rsp_ch.pattern_overflow = rsp_ovf_ff;

endmodule
`default_nettype wire

FILE: sim/contiguous_subsequence_matcher_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contiguous_subsequence_matcher_test
// Self-checking testbench for the contiguous subsequence matcher.
// ----------------------------------------------------------------------------
// The stimulus opens with a short directed run of edge cases. Random search
// cases follow, each made of a pattern and some texts that may contain it.
// Noise words and abandoned texts are mixed in. The driver offers words with
// random gaps. A search model predicts each text outcome as its words are
// accepted. The monitor stalls at random and checks every result word
// against the oldest prediction.
// ----------------------------------------------------------------------------
module contiguous_subsequence_matcher_test;
   import csm_pkg::*;

   localparam int MAX_PAT      = MAX_PATTERN_DEF;
   localparam int RANDOM_WORDS = 550;
   localparam int MIN_TEXTS    = 60;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 16;
   localparam int CYCLE_LIMIT  = 300000;

   typedef struct packed {
      logic                   op;
      logic [VALUE_WIDTH-1:0] value;
      logic                   last;
   } word_type;

   typedef struct packed {
      logic found;
      logic pattern_overflow;
   } outcome_type;

   logic clock;
   logic reset;

   csm_req_if req_if();
   csm_rsp_if rsp_if();

   contiguous_subsequence_matcher u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   word_type    pending_words[$];
   outcome_type expected_outcomes[$];

   // Search model state.
   logic [VALUE_WIDTH-1:0] pattern_mem[MAX_PAT];
   logic [VALUE_WIDTH-1:0] window_mem[MAX_PAT];
   int pattern_len = 0;
   int text_len    = 0;
   bit pattern_done       = 1'b0;
   bit pattern_overflowed = 1'b0;
   bit hit_seen           = 1'b0;

   int words_planned   = 0;
   int texts_planned   = 0;
   int results_checked = 0;
   int mismatch_count  = 0;
   int cycle_count     = 0;
   bit hold_off;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [VALUE_WIDTH-1:0] pick_symbol();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   // Gap before the next word; now and then a calm stretch with no gaps.
   function automatic int draw_gap(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) calm_left = $urandom_range(20, 60);
      return $urandom_range(0, 18);
   endfunction

   task automatic queue_word(input logic op, input logic [VALUE_WIDTH-1:0] value,
                             input logic last);
      word_type w;
      w.op    = op;
      w.value = value;
      w.last  = last;
      pending_words.push_back(w);
      words_planned++;
      if (op == OP_TEXT && last) texts_planned++;
   endtask

   task automatic note_mismatch(input string detail);
      if (mismatch_count < 10) $display("ERROR at %0t ns: %s", $time, detail);
      mismatch_count++;
   endtask

   function automatic void clear_text_window();
      for (int i = 0; i < MAX_PAT; i++) window_mem[i] = '0;
      text_len = 0;
      hit_seen = 1'b0;
   endfunction

   // The newest pattern_len window entries are compared with the pattern.
   function automatic bit window_holds_pattern();
      int base;
      if (pattern_len == 0) return 1'b1;
      if (text_len < pattern_len) return 1'b0;
      base = MAX_PAT - pattern_len;
      for (int i = 0; i < pattern_len; i++) begin
         if (window_mem[base + i] != pattern_mem[i]) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void search_step(input word_type w);
      outcome_type r;
      if (w.op == OP_PATTERN) begin
         if (pattern_done) begin
            pattern_len        = 0;
            pattern_done       = 1'b0;
            pattern_overflowed = 1'b0;
            clear_text_window();
         end
         if (pattern_len < MAX_PAT) begin
            pattern_mem[pattern_len] = w.value;
            pattern_len++;
         end else begin
            pattern_overflowed = 1'b1;
         end
         if (w.last) pattern_done = 1'b1;
      end else begin
         pattern_done = 1'b1;
         for (int i = 0; i < MAX_PAT - 1; i++) window_mem[i] = window_mem[i + 1];
         window_mem[MAX_PAT - 1] = w.value;
         if (text_len < MAX_PAT) text_len++;
         if (window_holds_pattern()) hit_seen = 1'b1;
         if (w.last) begin
            r.found            = !pattern_overflowed && hit_seen;
            r.pattern_overflow = pattern_overflowed;
            expected_outcomes.push_back(r);
            clear_text_window();
         end
      end
   endfunction

   // Driver: offers queued words, predicting each one as it is accepted.
   int       send_wait;
   int       send_calm;
   word_type offered;

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.op    <= OP_PATTERN;
         req_if.value <= '0;
         req_if.last  <= 1'b0;
         send_wait = 0;
         send_calm = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            search_step(offered);
            send_wait = draw_gap(send_calm);
         end
         if (!req_if.valid || req_if.ready) begin
            if (send_wait > 0) begin
               send_wait--;
               req_if.valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               offered = pending_words.pop_front();
               req_if.valid <= 1'b1;
               req_if.op    <= offered.op;
               req_if.value <= offered.value;
               req_if.last  <= offered.last;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: takes result words with random stalls and checks them.
   int          recv_wait;
   int          recv_calm;
   outcome_type wanted;

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         recv_wait = 0;
         recv_calm = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            results_checked++;
            if (expected_outcomes.size() == 0) begin
               note_mismatch($sformatf("unexpected result word found=%0b overflow=%0b",
                                       rsp_if.found, rsp_if.pattern_overflow));
            end else begin
               wanted = expected_outcomes.pop_front();
               if (rsp_if.found !== wanted.found ||
                   rsp_if.pattern_overflow !== wanted.pattern_overflow) begin
                  note_mismatch($sformatf(
                     "expected found=%0b overflow=%0b, got found=%0b overflow=%0b",
                     wanted.found, wanted.pattern_overflow,
                     rsp_if.found, rsp_if.pattern_overflow));
               end
            end
            recv_wait = draw_gap(recv_calm);
         end
         if (recv_wait > 0) begin
            recv_wait--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= !hold_off;
         end
      end
   end

   // One long hold on the result side so that the block backs up its input.
   initial begin
      hold_off = 1'b0;
      @(negedge reset);
      while (results_checked < 3) @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", CYCLE_LIMIT);
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      logic [VALUE_WIDTH-1:0] alphabet[3];
      logic [VALUE_WIDTH-1:0] pat[$];
      logic [VALUE_WIDTH-1:0] txt[$];
      int  n;
      int  len;
      int  pos;
      bit  open_end;

      reset = 1'b1;

      // With no pattern stored, every text reports found.
      queue_word(OP_TEXT, 32'h8000_0000, 1'b0);
      queue_word(OP_TEXT, 32'h7FFF_FFFF, 1'b1);
      queue_word(OP_PATTERN, 32'h8000_0000, 1'b0);
      queue_word(OP_PATTERN, 32'hFFFF_FFFF, 1'b1);
      // A text shorter than the pattern cannot match.
      queue_word(OP_TEXT, 32'hFFFF_FFFF, 1'b1);
      // The next text is matched against the same pattern.
      queue_word(OP_TEXT, 32'h8000_0000, 1'b0);
      queue_word(OP_TEXT, 32'hFFFF_FFFF, 1'b1);
      // An open pattern is closed by the first text word.
      queue_word(OP_PATTERN, 32'h0000_0000, 1'b0);
      queue_word(OP_TEXT, 32'h0000_0000, 1'b1);
      // One word more than the store holds.
      for (int i = 0; i <= MAX_PAT; i++) queue_word(OP_PATTERN, i, i == MAX_PAT);
      queue_word(OP_TEXT, 32'h0000_0000, 1'b1);
      // A pattern word in the middle of a text drops that text.
      queue_word(OP_TEXT, 32'h0000_0005, 1'b0);
      queue_word(OP_PATTERN, 32'h0000_0005, 1'b1);
      queue_word(OP_TEXT, 32'h0000_0005, 1'b1);

      words_planned = 0;
      texts_planned = 0;
      while (words_planned < RANDOM_WORDS || texts_planned < MIN_TEXTS) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               repeat ($urandom_range(1, 6))
                  queue_word(1'($urandom_range(0, 1)), pick_symbol(),
                             $urandom_range(0, 2) == 0);
            end
            2: begin
               // Text left unfinished; the next pattern word throws it away.
               repeat ($urandom_range(1, 5)) queue_word(OP_TEXT, pick_symbol(), 1'b0);
            end
            default: begin
               for (int i = 0; i < 3; i++) alphabet[i] = pick_symbol();
               if ($urandom_range(0, 7) == 0) n = $urandom_range(MAX_PAT + 1, MAX_PAT + 4);
               else if ($urandom_range(0, 5) == 0) n = MAX_PAT;
               else n = $urandom_range(1, 6);
               pat.delete();
               for (int i = 0; i < n; i++) pat.push_back(alphabet[2'($urandom_range(0, 2))]);
               open_end = ($urandom_range(0, 5) == 0);
               for (int i = 0; i < n; i++)
                  queue_word(OP_PATTERN, pat[i], !open_end && i == n - 1);
               repeat ($urandom_range(1, 4)) begin
                  if ($urandom_range(0, 4) == 0) len = $urandom_range(MAX_PAT + 1, 24);
                  else len = $urandom_range(1, 12);
                  txt.delete();
                  for (int i = 0; i < len; i++)
                     txt.push_back(alphabet[2'($urandom_range(0, 2))]);
                  if (n <= len && $urandom_range(0, 1) == 1) begin
                     pos = $urandom_range(0, len - n);
                     for (int i = 0; i < n; i++) txt[pos + i] = pat[i];
                  end
                  for (int i = 0; i < len; i++) queue_word(OP_TEXT, txt[i], i == len - 1);
               end
            end
         endcase
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending_words.size() > 0 || req_if.valid) @(posedge clock);
      while (expected_outcomes.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
